[rtl/core/utf8_to_utf16_name_encoder_assert.svh]
// Assertion macros used by the port checker of the UTF-8 to UTF-16 name encoder.
`ifndef UTF8_TO_UTF16_NAME_ENCODER_ASSERT_SVH
`define UTF8_TO_UTF16_NAME_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U8U16_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define U8U16_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/u8u16enc_pkg.sv]
// Types, constants and helper functions of the UTF-8 to UTF-16 name encoder.
`default_nettype none

package u8u16enc_pkg;

	localparam int MAX_UNITS_DEF = 36;

	// Result queue between the decode stage and the output port.
	localparam int RES_AW    = 2;
	localparam int RES_DEPTH = 1 << RES_AW;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_TOO_LONG = 2'd2
	} status_t;

	localparam logic [7:0]  LEAD2_LO   = 8'hC2;
	localparam logic [7:0]  LEAD2_HI   = 8'hDF;
	localparam logic [7:0]  LEAD3_LO   = 8'hE0;
	localparam logic [7:0]  LEAD3_HI   = 8'hEF;
	localparam logic [7:0]  LEAD4_LO   = 8'hF0;
	localparam logic [7:0]  LEAD4_HI   = 8'hF4;
	localparam logic [20:0] CP_MAX     = 21'h10FFFF;
	localparam logic [20:0] SURR_LO    = 21'h00D800;
	localparam logic [20:0] SURR_HI    = 21'h00DFFF;
	localparam logic [20:0] MIN_CLS2   = 21'h000080;
	localparam logic [20:0] MIN_CLS3   = 21'h000800;
	localparam logic [20:0] MIN_CLS4   = 21'h010000;
	localparam logic [5:0]  HI_SURR_TAG = 6'b110110;
	localparam logic [5:0]  LO_SURR_TAG = 6'b110111;

	typedef struct packed {
		logic [15:0] code_unit;
		logic [5:0]  unit_index;
		logic        is_status;
		status_t     status;
		logic        last;
	} result_t;

	// C0 and C1 control characters, DEL included.
	function automatic logic is_ctl(input logic [20:0] c);
		return (c < 21'd32) || (c >= 21'd127 && c <= 21'd159);
	endfunction

endpackage

`default_nettype wire

[rtl/core/utf8_to_utf16_name_encoder.sv]
// UTF-8 to UTF-16 name encoder: strict decode, surrogate pairs, length check.
//
// Input: s_tvalid/s_tready/s_tdata, one UTF-8 byte per request; a zero byte
// ends the string. Output: m_tvalid/m_tready/m_tdata/m_tuser/m_tlast, one
// result per request. A unit result carries a UTF-16 code unit and its index
// in the name field; the terminator yields one status result (m_tuser high).
// m_tlast marks the final result caused by an input byte.
// Each accepted byte is registered in the input stage, decoded against the
// sequence state and pushed into a 4-entry result queue, whose head drives
// the output; a four-byte character pushes a surrogate pair.
// Throughput: one byte per cycle while the queue has room; the queue drains
// one result per cycle while m_tready is high. The decode stage advances
// while the queue has at least two free entries.
// After the first error no unit results go out until the terminator, whose
// status result reports that error; the terminator then clears all state.
// Reset (arst_n low) empties the queue and clears the sequence state.
// When the receiver stalls, the queue fills and s_tready drops; nothing is
// lost and the head result holds steady on the output.
`default_nettype none

module utf8_to_utf16_name_encoder #(
	parameter int MAX_UNITS = u8u16enc_pkg::MAX_UNITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // [15:0] code_unit, [21:16] unit_index, [23:22] status
	output logic             m_tuser,   // [0] is_status
	output logic             m_tlast    // last
);
	import u8u16enc_pkg::*;

	// Input stage
	logic        vld_s1;
	logic [7:0]  byte_s1;
	logic        fire_s1;

	// Sequence state
	logic [1:0]  pend_q, pend_n;
	logic [20:0] cp_q, cp_n;
	logic [1:0]  cls_q, cls_n;
	logic [5:0]  units_q, units_n;
	status_t     sticky_q, sticky_n;

	// Result queue
	result_t            res_mem [RES_DEPTH];
	logic [RES_AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [RES_AW:0]    cnt_q;
	logic [1:0]         n_push;
	result_t            r0, r1;
	logic               pop;

	// Decode helpers
	logic [20:0] cp_asm;
	logic [20:0] c_fin;
	logic [20:0] cp_min;
	logic        need2;
	logic [6:0]  units_need;
	logic        fits;
	logic [19:0] cp_off;
	logic        cp_bad;
	status_t     end_st;

	assign fire_s1  = vld_s1 && (cnt_q <= (RES_AW+1)'(RES_DEPTH - 2));
	assign s_tready = !vld_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	assign cp_asm = {cp_q[14:0], byte_s1[5:0]};
	assign c_fin  = (pend_q == 2'd0) ? {13'd0, byte_s1} : cp_asm;

	always_comb begin
		case (cls_q)
			2'd1:    cp_min = MIN_CLS2;
			2'd2:    cp_min = MIN_CLS3;
			default: cp_min = MIN_CLS4;
		endcase
	end

	assign cp_bad = (cp_asm < cp_min) || (cp_asm > CP_MAX) ||
		(cp_asm >= SURR_LO && cp_asm <= SURR_HI) || is_ctl(cp_asm);

	assign need2      = |c_fin[20:16];
	assign units_need = {1'b0, units_q} + (need2 ? 7'd2 : 7'd1);
	assign fits       = units_need <= 7'(MAX_UNITS);
	assign cp_off     = 20'(c_fin - MIN_CLS4);
	assign end_st     = (sticky_q == ST_OK && pend_q != 2'd0) ? ST_INVALID : sticky_q;

	always_comb begin
		pend_n   = pend_q;
		cp_n     = cp_q;
		cls_n    = cls_q;
		units_n  = units_q;
		sticky_n = sticky_q;
		n_push   = 2'd0;
		r0       = '0;
		r1       = '0;
		if (byte_s1 == 8'd0) begin
			// terminator: report and clear
			r0.is_status = 1'b1;
			r0.status    = end_st;
			r0.last      = 1'b1;
			n_push       = 2'd1;
			pend_n       = 2'd0;
			cp_n         = '0;
			cls_n        = 2'd0;
			units_n      = 6'd0;
			sticky_n     = ST_OK;
		end else if (sticky_q != ST_OK) begin
			// drop bytes until the terminator
		end else if (pend_q == 2'd0) begin
			if (!byte_s1[7]) begin
				if (is_ctl(c_fin)) begin
					sticky_n = ST_INVALID;
				end else if (!fits) begin
					sticky_n = ST_TOO_LONG;
				end else begin
					r0.code_unit  = c_fin[15:0];
					r0.unit_index = units_q;
					r0.last       = 1'b1;
					n_push        = 2'd1;
					units_n       = units_q + 6'd1;
				end
			end else if (byte_s1 >= LEAD2_LO && byte_s1 <= LEAD2_HI) begin
				cp_n   = {16'd0, byte_s1[4:0]};
				pend_n = 2'd1;
				cls_n  = 2'd1;
			end else if (byte_s1 >= LEAD3_LO && byte_s1 <= LEAD3_HI) begin
				cp_n   = {17'd0, byte_s1[3:0]};
				pend_n = 2'd2;
				cls_n  = 2'd2;
			end else if (byte_s1 >= LEAD4_LO && byte_s1 <= LEAD4_HI) begin
				cp_n   = {18'd0, byte_s1[2:0]};
				pend_n = 2'd3;
				cls_n  = 2'd3;
			end else begin
				sticky_n = ST_INVALID;
			end
		end else if (byte_s1[7:6] != 2'b10) begin
			sticky_n = ST_INVALID;
			pend_n   = 2'd0;
		end else if (pend_q != 2'd1) begin
			cp_n   = cp_asm;
			pend_n = pend_q - 2'd1;
		end else begin
			// last continuation byte: check and emit
			pend_n = 2'd0;
			cp_n   = '0;
			cls_n  = 2'd0;
			if (cp_bad) begin
				sticky_n = ST_INVALID;
			end else if (!fits) begin
				sticky_n = ST_TOO_LONG;
			end else if (need2) begin
				r0.code_unit  = {HI_SURR_TAG, cp_off[19:10]};
				r0.unit_index = units_q;
				r1.code_unit  = {LO_SURR_TAG, cp_off[9:0]};
				r1.unit_index = units_q + 6'd1;
				r1.last       = 1'b1;
				n_push        = 2'd2;
				units_n       = units_q + 6'd2;
			end else begin
				r0.code_unit  = c_fin[15:0];
				r0.unit_index = units_q;
				r0.last       = 1'b1;
				n_push        = 2'd1;
				units_n       = units_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= 2'd0;
			cp_q     <= '0;
			cls_q    <= 2'd0;
			units_q  <= 6'd0;
			sticky_q <= ST_OK;
		end else if (fire_s1) begin
			pend_q   <= pend_n;
			cp_q     <= cp_n;
			cls_q    <= cls_n;
			units_q  <= units_n;
			sticky_q <= sticky_n;
		end
	end

	assign pop = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + (fire_s1 ? RES_AW'(n_push) : '0);
			rd_ptr_q <= rd_ptr_q + RES_AW'(pop);
			cnt_q    <= cnt_q + (fire_s1 ? (RES_AW+1)'(n_push) : '0) - (RES_AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && n_push != 2'd0) begin
			res_mem[wr_ptr_q] <= r0;
		end
		if (fire_s1 && n_push == 2'd2) begin
			res_mem[wr_ptr_q + RES_AW'(1)] <= r1;
		end
	end

	assign m_tvalid = cnt_q != '0;
	assign m_tdata  = {res_mem[rd_ptr_q].status, res_mem[rd_ptr_q].unit_index,
		res_mem[rd_ptr_q].code_unit};
	assign m_tuser  = res_mem[rd_ptr_q].is_status;
	assign m_tlast  = res_mem[rd_ptr_q].last;

endmodule

`default_nettype wire

[rtl/core/u8u16enc_chk.sv]
// Port-level checker for the UTF-8 to UTF-16 name encoder, with its bind.
`default_nettype none

`include "utf8_to_utf16_name_encoder_assert.svh"

module u8u16enc_chk #(
	parameter int MAX_UNITS = u8u16enc_pkg::MAX_UNITS_DEF
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata,
	input wire logic        m_tuser,
	input wire logic        m_tlast
);
	import u8u16enc_pkg::*;

	// a status result is always the only and final result of its byte
	`U8U16_ASSERT_NOW(a_status_last, clk, arst_n, m_tvalid && m_tuser, m_tlast && m_tdata[21:0] == 22'd0, "status result not final or not blank")
	// unit results carry ok status and an index inside the name field
	`U8U16_ASSERT_NOW(a_unit_fields, clk, arst_n, m_tvalid && !m_tuser, m_tdata[23:22] == ST_OK && m_tdata[21:16] < 6'(MAX_UNITS), "unit result has bad status or index")
	// status code 3 never appears
	`U8U16_ASSERT_NOW(a_status_code, clk, arst_n, m_tvalid, m_tdata[23:22] != 2'd3, "undefined status code")
	// hold the head result while the receiver stalls
	`U8U16_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed under stall")

endmodule

bind utf8_to_utf16_name_encoder u8u16enc_chk #(.MAX_UNITS(MAX_UNITS)) u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire

[tb/name_encoder_checker.sv]
// Checker for the UTF-8 to UTF-16 name encoder: predicts code units and status, compares results.
`timescale 1ns / 1ps

module name_encoder_checker #(
	parameter int MAX_UNITS = u8u16enc_pkg::MAX_UNITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // [15:0] code_unit, [21:16] unit_index, [23:22] status
	input  logic        m_tuser,   // [0] is_status
	input  logic        m_tlast,
	output int          fail_count,
	output int          pending_results
);
	import u8u16enc_pkg::*;

	typedef enum logic [1:0] {SEQ_NONE, SEQ_TWO, SEQ_THREE, SEQ_FOUR} seq_class_t;

	logic [1:0]  bytes_owed;
	logic [20:0] cp_acc;
	seq_class_t  seq_class;
	logic [5:0]  unit_count;
	status_t     first_error;
	result_t     expected_utf16[$];
	result_t     oldest;

	function automatic logic is_control_char(input logic [20:0] cp);
		return (cp <= 21'h1F) || (cp >= 21'h7F && cp <= 21'h9F);
	endfunction

	function automatic void clear_decoder();
		bytes_owed = 2'd0;
		cp_acc = 21'd0;
		seq_class = SEQ_NONE;
		unit_count = 6'd0;
		first_error = ST_OK;
	endfunction

	function automatic void queue_result(input logic [15:0] unit_val, input logic [5:0] index,
			input logic status_flag, input status_t code, input logic last_flag);
		result_t r;
		r.code_unit = unit_val;
		r.unit_index = index;
		r.is_status = status_flag;
		r.status = code;
		r.last = last_flag;
		expected_utf16.push_back(r);
	endfunction

	// Emit one unit or a surrogate pair, or latch too-long if the name field is full.
	function automatic void emit_code_point(input logic [20:0] cp);
		logic [20:0] offset;
		if (cp >= MIN_CLS4) begin
			if (int'(unit_count) + 2 > MAX_UNITS) begin
				first_error = ST_TOO_LONG;
			end else begin
				offset = cp - MIN_CLS4;
				queue_result(16'hD800 + offset[19:10], unit_count, 1'b0, ST_OK, 1'b0);
				queue_result(16'hDC00 + offset[9:0], unit_count + 6'd1, 1'b0, ST_OK, 1'b1);
				unit_count = unit_count + 6'd2;
			end
		end else if (int'(unit_count) + 1 > MAX_UNITS) begin
			first_error = ST_TOO_LONG;
		end else begin
			queue_result(cp[15:0], unit_count, 1'b0, ST_OK, 1'b1);
			unit_count = unit_count + 6'd1;
		end
	endfunction

	function automatic void transcode_byte(input logic [7:0] b);
		status_t     end_status;
		logic [20:0] floor_cp;
		logic [20:0] cp;
		if (b == 8'h00) begin
			end_status = first_error;
			if (end_status == ST_OK && bytes_owed != 2'd0)
				end_status = ST_INVALID;
			queue_result(16'h0000, 6'd0, 1'b1, end_status, 1'b1);
			clear_decoder();
		end else if (first_error == ST_OK) begin
			if (bytes_owed == 2'd0) begin
				if (b < 8'h80) begin
					if (is_control_char({13'd0, b}))
						first_error = ST_INVALID;
					else
						emit_code_point({13'd0, b});
				end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
					cp_acc = {16'd0, b[4:0]};
					bytes_owed = 2'd1;
					seq_class = SEQ_TWO;
				end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
					cp_acc = {17'd0, b[3:0]};
					bytes_owed = 2'd2;
					seq_class = SEQ_THREE;
				end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
					cp_acc = {18'd0, b[2:0]};
					bytes_owed = 2'd3;
					seq_class = SEQ_FOUR;
				end else begin
					first_error = ST_INVALID;
				end
			end else if (b[7:6] != 2'b10) begin
				first_error = ST_INVALID;
				bytes_owed = 2'd0;
			end else begin
				cp_acc = {cp_acc[14:0], b[5:0]};
				bytes_owed = bytes_owed - 2'd1;
				if (bytes_owed == 2'd0) begin
					cp = cp_acc;
					case (seq_class)
					SEQ_TWO:   floor_cp = MIN_CLS2;
					SEQ_THREE: floor_cp = MIN_CLS3;
					default:   floor_cp = MIN_CLS4;
					endcase
					cp_acc = 21'd0;
					seq_class = SEQ_NONE;
					// reject overlong forms, surrogates, out-of-range values and controls
					if (cp < floor_cp || cp > CP_MAX || (cp >= SURR_LO && cp <= SURR_HI) ||
							is_control_char(cp))
						first_error = ST_INVALID;
					else
						emit_code_point(cp);
				end
			end
		end
	endfunction

	function automatic void check_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_decoder();
			expected_utf16.delete();
			fail_count = 0;
			pending_results = 0;
		end else begin
			if (s_tvalid && s_tready)
				transcode_byte(s_tdata);
			if (m_tvalid && m_tready) begin
				if (expected_utf16.size() == 0) begin
					$error("result with nothing expected: tdata 0x%h tuser %b tlast %b",
						m_tdata, m_tuser, m_tlast);
					fail_count++;
				end else begin
					oldest = expected_utf16.pop_front();
					check_field("code_unit", oldest.code_unit, m_tdata[15:0]);
					check_field("unit_index", oldest.unit_index, m_tdata[21:16]);
					check_field("status", oldest.status, m_tdata[23:22]);
					check_field("is_status", oldest.is_status, m_tuser);
					check_field("last", oldest.last, m_tlast);
				end
			end
			pending_results = expected_utf16.size();
		end
	end

endmodule

[tb/testbench.sv]
// Top of the name encoder testbench: clock, reset, byte stimulus, result drain and verdict.
`timescale 1ns / 1ps

module testbench;

	localparam int STALL_LIMIT     = 2000;
	localparam int ITEM_TARGET     = 1900;
	localparam int DRAIN_CYCLES    = 8;
	localparam int PRESSURE_RESULT = 500;
	localparam int PRESSURE_CYCLES = 300;
	localparam int PAUSE_STRING    = 60;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	int          fail_count;
	int          pending_results;
	int          idle_cycles = 0;
	int          sent_bytes = 0;
	logic        tx_burst = 1'b0;
	logic [7:0]  name_bytes[$];

	utf8_to_utf16_name_encoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	name_encoder_checker result_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.m_tlast         (m_tlast),
		.fail_count      (fail_count),
		.pending_results (pending_results)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Encode cp in nbytes bytes; a short cp in a long form gives an overlong sequence.
	function automatic void put_utf8(input logic [20:0] cp, input int nbytes);
		case (nbytes)
		1: name_bytes.push_back(cp[7:0]);
		2: begin
			name_bytes.push_back({3'b110, cp[10:6]});
			name_bytes.push_back({2'b10, cp[5:0]});
		end
		3: begin
			name_bytes.push_back({4'b1110, cp[15:12]});
			name_bytes.push_back({2'b10, cp[11:6]});
			name_bytes.push_back({2'b10, cp[5:0]});
		end
		default: begin
			name_bytes.push_back({5'b11110, cp[20:18]});
			name_bytes.push_back({2'b10, cp[17:12]});
			name_bytes.push_back({2'b10, cp[11:6]});
			name_bytes.push_back({2'b10, cp[5:0]});
		end
		endcase
	endfunction

	function automatic void put_good_char(input int nbytes);
		logic [20:0] cp;
		case (nbytes)
		1: put_utf8(21'($urandom_range(32, 126)), 1);
		2: put_utf8(21'($urandom_range(160, 2047)), 2);
		3: begin
			cp = 21'($urandom_range(2048, 65535));
			if (cp >= 21'hD800 && cp <= 21'hDFFF)
				cp = cp - 21'h800;
			put_utf8(cp, 3);
		end
		default: put_utf8(21'($urandom_range(65536, 1114111)), 4);
		endcase
	endfunction

	// Append a random byte or a broken or forbidden sequence; 1 means end the name here.
	function automatic bit put_fault();
		int nbytes;
		int kind;
		logic [20:0] cp;
		kind = $urandom_range(0, 7);
		case (kind)
		0: name_bytes.push_back(8'($urandom_range(1, 255)));
		1: begin
			case ($urandom_range(0, 2))
			0: name_bytes.push_back(8'($urandom_range(1, 31)));
			1: name_bytes.push_back(8'h7F);
			default: put_utf8(21'($urandom_range(128, 159)), 2);
			endcase
		end
		2: put_utf8(21'($urandom_range(16'hD800, 16'hDFFF)), 3);
		3: put_utf8(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
		4: begin
			nbytes = $urandom_range(2, 4);
			cp = 21'((nbytes == 2) ? $urandom_range(0, 127) :
				(nbytes == 3) ? $urandom_range(0, 2047) : $urandom_range(0, 65535));
			put_utf8(cp, nbytes);
		end
		5, 6: begin
			nbytes = $urandom_range(2, 4);
			put_good_char(nbytes);
			repeat ($urandom_range(1, nbytes - 1))
				void'(name_bytes.pop_back());
			if (kind == 6)
				return 1'b1;
			name_bytes.push_back(8'($urandom_range(0, 1) ? $urandom_range(1, 127) :
				$urandom_range(192, 255)));
		end
		default: name_bytes.push_back(8'($urandom_range(0, 1) ? $urandom_range(128, 193) :
			$urandom_range(245, 255)));
		endcase
		return 1'b0;
	endfunction

	task automatic send_byte(input logic [7:0] value);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= value;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		sent_bytes++;
	endtask

	task automatic send_name();
		foreach (name_bytes[i])
			send_byte(name_bytes[i]);
		name_bytes.delete();
	endtask

	initial begin : byte_source
		int   string_count;
		int   n_chars;
		int   fault_at;
		int   r;
		bit   long_name;
		bit   cut;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		arst_n = 1'b0;
		string_count = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// extreme values of several sequence lengths, then an empty name and names with errors
		name_bytes = {8'h41, 8'hC2, 8'hA0, 8'hF0, 8'h90, 8'h80, 8'h80,
			8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h00,
			8'hEF, 8'hBF, 8'hBF, 8'h7E, 8'h00,
			8'h00,
			8'h80, 8'h00,
			8'hC2, 8'h41, 8'h00,
			8'hE0, 8'h80, 8'h80, 8'h00,
			8'h7F, 8'h41, 8'h00,
			8'hE3, 8'h00};
		send_name();

		while (sent_bytes < ITEM_TARGET) begin
			long_name = ($urandom_range(0, 7) == 0);
			n_chars = long_name ? $urandom_range(30, 40) : $urandom_range(0, 12);
			fault_at = ($urandom_range(0, 9) < 3) ? $urandom_range(0, n_chars) : -1;
			cut = 1'b0;
			for (int i = 0; i <= n_chars && !cut; i++) begin
				if (i == fault_at)
					cut = put_fault();
				if (i < n_chars && !cut) begin
					r = $urandom_range(0, 9);
					put_good_char(r < 4 ? 1 : r < 6 ? 2 : r < 8 ? 3 : 4);
				end
			end
			name_bytes.push_back(8'h00);
			tx_burst = ($urandom_range(0, 3) == 0);
			if (string_count == PAUSE_STRING) begin
				// hold until every result is out
				s_tvalid <= 1'b0;
				do @(negedge clk); while (pending_results != 0);
			end
			send_name();
			string_count++;
		end

		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending_results != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("** utf8_to_utf16_name_encoder: PASSED **");
		else
			$display("** utf8_to_utf16_name_encoder: FAILED **");
		$finish;
	end

	initial begin : result_drain
		int   hold;
		int   taken;
		logic rx_burst;
		m_tready = 1'b0;
		hold = 0;
		taken = 0;
		rx_burst = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			m_tready <= (hold == 0);
			@(posedge clk);
			if (hold != 0) begin
				hold--;
			end else if (m_tvalid) begin
				taken++;
				if ($urandom_range(0, 31) == 0)
					rx_burst = !rx_burst;
				// one long hold so the queue fills and the input stalls
				if (taken == PRESSURE_RESULT)
					hold = PRESSURE_CYCLES;
				else
					hold = rx_burst ? 0 : $urandom_range(0, 15);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == STALL_LIMIT) begin
			$display("** utf8_to_utf16_name_encoder: FAILED **");
			$finish;
		end
	end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/u8u16enc_pkg.sv
rtl/core/utf8_to_utf16_name_encoder.sv
rtl/core/u8u16enc_chk.sv
tb/name_encoder_checker.sv
tb/testbench.sv
